// ----- hw/rtl/hsv_to_rgb_converter_core_defines.svh -----
// Assertion macros used by the converter's top-level RTL file.
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define HSV2RGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

  // Default number of fraction bits in every fixed-point field.
  localparam int FRAC_BITS_DEF = 16;

  // Colour wheel sector, the integer part of hue * 6.
  typedef enum logic [2:0] {
    SEC_RED_TO_YELLOW     = 3'd0,
    SEC_YELLOW_TO_GREEN   = 3'd1,
    SEC_GREEN_TO_CYAN     = 3'd2,
    SEC_CYAN_TO_BLUE      = 3'd3,
    SEC_BLUE_TO_MAGENTA   = 3'd4,
    SEC_MAGENTA_TO_RED    = 3'd5
  } sector_t;

endpackage

// ----- hw/rtl/hsv2rgb_hsv_if.sv -----
interface hsv2rgb_hsv_if #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   saturation;
  logic [FRAC_BITS+1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ----- hw/rtl/hsv2rgb_rgb_if.sv -----
interface hsv2rgb_rgb_if #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS+1:0] red;
  logic [FRAC_BITS+1:0] green;
  logic [FRAC_BITS+1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hw/rtl/hsv2rgb_sector.sv -----
module hsv2rgb_sector #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [FRAC_BITS-1:0] hue,
  output hsv2rgb_pkg::sector_t sector_r,
  output logic [FRAC_BITS-1:0] frac_r,
  output logic [FRAC_BITS:0]   frac_c_r
);
  import hsv2rgb_pkg::*;

  localparam int HW = FRAC_BITS + 3;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [HW-1:0]        hue_x;
  logic [HW-1:0]        h6;
  sector_t              sector_nxt;
  logic [FRAC_BITS-1:0] frac_nxt;
  logic [FRAC_BITS:0]   frac_c_nxt;

  // hue * 6 as (hue << 2) + (hue << 1).
  assign hue_x      = {3'b000, hue};
  assign h6         = (hue_x << 2) + (hue_x << 1);
  assign sector_nxt = sector_t'(h6[HW-1:FRAC_BITS]);
  assign frac_nxt   = h6[FRAC_BITS-1:0];
  assign frac_c_nxt = ONE - {1'b0, frac_nxt};

  always_ff @(posedge clk) begin
    if (adv) begin
      sector_r <= sector_nxt;
      frac_r   <= frac_nxt;
      frac_c_r <= frac_c_nxt;
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_level.sv -----
module hsv2rgb_level #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic [2:0]           adv,
  input  logic [FRAC_BITS:0]   sat,
  input  logic [FRAC_BITS:0]   x,
  input  logic [FRAC_BITS+1:0] val,
  output logic [FRAC_BITS+1:0] lvl_r
);
  import hsv2rgb_pkg::*;

  localparam int SPW = 2 * FRAC_BITS + 2;
  localparam int VPW = 2 * FRAC_BITS + 3;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [SPW-1:0]       sx_prod;
  logic [FRAC_BITS:0]   sx_nxt;
  logic [FRAC_BITS:0]   sx_r;
  logic [FRAC_BITS:0]   fac_nxt;
  logic [FRAC_BITS:0]   fac_r;
  logic [VPW-1:0]       v_prod;
  logic [FRAC_BITS+1:0] lvl_nxt;

  // S * x, truncated back to the fraction scale.
  assign sx_prod = {{(FRAC_BITS+1){1'b0}}, sat} * {{(FRAC_BITS+1){1'b0}}, x};
  assign sx_nxt  = sx_prod[2*FRAC_BITS:FRAC_BITS];

  // A factor of zero or below gives a level of zero.
  assign fac_nxt = (sx_r >= ONE) ? '0 : (ONE - sx_r);

  assign v_prod  = {{(FRAC_BITS+1){1'b0}}, val} * {{(FRAC_BITS+2){1'b0}}, fac_r};
  assign lvl_nxt = v_prod[2*FRAC_BITS+1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sx_r <= sx_nxt;
    end
    if (adv[1]) begin
      fac_r <= fac_nxt;
    end
    if (adv[2]) begin
      lvl_r <= lvl_nxt;
    end
  end

endmodule

// ----- hw/rtl/hsv2rgb_route.sv -----
module hsv2rgb_route #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic                 hdr_mode,
  input  logic                 s_zero,
  input  hsv2rgb_pkg::sector_t sector,
  input  logic [FRAC_BITS+1:0] val,
  input  logic [FRAC_BITS+1:0] lvl_p,
  input  logic [FRAC_BITS+1:0] lvl_q,
  input  logic [FRAC_BITS+1:0] lvl_t,
  output logic [FRAC_BITS+1:0] red_r,
  output logic [FRAC_BITS+1:0] green_r,
  output logic [FRAC_BITS+1:0] blue_r
);
  import hsv2rgb_pkg::*;

  localparam logic [FRAC_BITS+1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS+1:0] r_sel, g_sel, b_sel;
  logic [FRAC_BITS+1:0] red_nxt, green_nxt, blue_nxt;
  logic                 clamp_en;

  always_comb begin
    unique case (sector)
      SEC_RED_TO_YELLOW:   begin r_sel = val;   g_sel = lvl_t; b_sel = lvl_p; end
      SEC_YELLOW_TO_GREEN: begin r_sel = lvl_q; g_sel = val;   b_sel = lvl_p; end
      SEC_GREEN_TO_CYAN:   begin r_sel = lvl_p; g_sel = val;   b_sel = lvl_t; end
      SEC_CYAN_TO_BLUE:    begin r_sel = lvl_p; g_sel = lvl_q; b_sel = val;   end
      SEC_BLUE_TO_MAGENTA: begin r_sel = lvl_t; g_sel = lvl_p; b_sel = val;   end
      default:             begin r_sel = val;   g_sel = lvl_p; b_sel = lvl_q; end
    endcase
  end

  // Grey pixels pass unclamped; all levels already equal the value there.
  assign clamp_en  = !hdr_mode && !s_zero;
  assign red_nxt   = (clamp_en && (r_sel > ONE)) ? ONE : r_sel;
  assign green_nxt = (clamp_en && (g_sel > ONE)) ? ONE : g_sel;
  assign blue_nxt  = (clamp_en && (b_sel > ONE)) ? ONE : b_sel;

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
// HSV to RGB pixel converter. Hue is a fraction of a turn (FRAC_BITS bits),
// saturation has one integer bit and value two, and red, green and blue come
// out in the same format as value. The block takes one item in every clock
// cycle while its first stage is free to advance, and each item passes
// through five register stages (hue split, S times fraction, factor, V
// times factor, routing and clamp). Each stage holds its item only while
// its successor is full and stalled, so a stall on the output fills bubbles
// before it stops the input. When hdr_mode is clear, each channel is
// clamped to 1.0; grey pixels (zero saturation) always pass the value
// through unchanged. hdr_mode is written through cfg_wr_en and cfg_wr_data
// and should only change while no item is in flight.
module hsv_to_rgb_converter_core #(
  parameter int FRAC_BITS = hsv2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hsv2rgb_hsv_if.sink      in_pix,
  hsv2rgb_rgb_if.source    out_pix,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data
);
  import hsv2rgb_pkg::*;

`include "hsv_to_rgb_converter_core_defines.svh"

  localparam int NSTAGE = 5;
  localparam logic [FRAC_BITS:0]   ONE_S = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+1:0] ONE_V = {2'b01, {FRAC_BITS{1'b0}}};

  // Stage control: a valid bit per stage and the advance enables.
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] adv;
  logic              hdr_mode_r;

  // Side band that travels with each item.
  logic [FRAC_BITS:0]   sat1_r;
  logic [FRAC_BITS+1:0] val_r [4];
  logic                 szero_r [4];
  sector_t              sec0_r;
  sector_t              sec_r [1:3];

  logic [FRAC_BITS-1:0] frac1;
  logic [FRAC_BITS:0]   frac_c1;
  logic [FRAC_BITS+1:0] lvl_p, lvl_q, lvl_t;

  // A stage moves on when it is empty or its successor moves on.
  always_comb begin
    adv[NSTAGE-1] = !vld_r[NSTAGE-1] || out_pix.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_pix.valid;
    end
    for (int k = 1; k < NSTAGE; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      hdr_mode_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_wr_en) begin
        hdr_mode_r <= cfg_wr_data;
      end
    end
  end

  // Side-band delay line; index k holds the item of stage k + 1.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sat1_r     <= in_pix.saturation;
      val_r[0]   <= in_pix.value;
      szero_r[0] <= (in_pix.saturation == '0);
    end
    for (int k = 1; k < 4; k++) begin
      if (adv[k]) begin
        val_r[k]   <= val_r[k-1];
        szero_r[k] <= szero_r[k-1];
      end
    end
    if (adv[1]) begin
      sec_r[1] <= sec0_r;
    end
    for (int k = 2; k < 4; k++) begin
      if (adv[k]) begin
        sec_r[k] <= sec_r[k-1];
      end
    end
  end

  hsv2rgb_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
    .clk      (clk),
    .adv      (adv[0]),
    .hue      (in_pix.hue),
    .sector_r (sec0_r),
    .frac_r   (frac1),
    .frac_c_r (frac_c1)
  );

  // p = V*(1-S), q = V*(1-S*f), t = V*(1-S*(1-f)).
  hsv2rgb_level #(.FRAC_BITS(FRAC_BITS)) u_level_p (
    .clk   (clk),
    .adv   (adv[3:1]),
    .sat   (sat1_r),
    .x     (ONE_S),
    .val   (val_r[2]),
    .lvl_r (lvl_p)
  );

  hsv2rgb_level #(.FRAC_BITS(FRAC_BITS)) u_level_q (
    .clk   (clk),
    .adv   (adv[3:1]),
    .sat   (sat1_r),
    .x     ({1'b0, frac1}),
    .val   (val_r[2]),
    .lvl_r (lvl_q)
  );

  hsv2rgb_level #(.FRAC_BITS(FRAC_BITS)) u_level_t (
    .clk   (clk),
    .adv   (adv[3:1]),
    .sat   (sat1_r),
    .x     (frac_c1),
    .val   (val_r[2]),
    .lvl_r (lvl_t)
  );

  hsv2rgb_route #(.FRAC_BITS(FRAC_BITS)) u_route (
    .clk      (clk),
    .adv      (adv[4]),
    .hdr_mode (hdr_mode_r),
    .s_zero   (szero_r[3]),
    .sector   (sec_r[3]),
    .val      (val_r[3]),
    .lvl_p    (lvl_p),
    .lvl_q    (lvl_q),
    .lvl_t    (lvl_t),
    .red_r    (out_pix.red),
    .green_r  (out_pix.green),
    .blue_r   (out_pix.blue)
  );

  assign in_pix.ready  = adv[0];
  assign out_pix.valid = vld_r[NSTAGE-1];

  // An accepted item must occupy the first stage in the next cycle.
  `HSV2RGB_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_pix.valid && in_pix.ready, vld_r[0], "accepted item lost at stage one")
  // With every stage full and the output stalled, nothing may enter.
  `HSV2RGB_ASSERT_NOW(a_full_blocks, clk, rst_n, (&vld_r) && !out_pix.ready, !in_pix.ready, "input taken while pipeline full and stalled")
  // Without hdr mode only grey pixels may exceed 1.0.
  `HSV2RGB_ASSERT_NOW(a_clamp, clk, rst_n, out_pix.valid && !hdr_mode_r, (out_pix.red <= ONE_V && out_pix.green <= ONE_V && out_pix.blue <= ONE_V) || (out_pix.red == out_pix.green && out_pix.green == out_pix.blue), "channel above 1.0 with hdr mode clear")

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  // Fixed-point geometry of the converter at its default width.
  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned UNITY = 64'd1 << FB;
  localparam longint unsigned FRAC_MASK = UNITY - 1;
  localparam longint unsigned CHAN_MAX = (64'd1 << (FB + 2)) - 1;

  // The pipeline is five register stages deep; the settling pause in
  // wait_drained is reckoned from that depth.
  localparam int PIPE_DEPTH = 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [FB-1:0] hue;
    logic [FB:0]   sat;
    logic [FB+1:0] val;
  } hsv_pixel_t;

  typedef struct packed {
    logic [FB+1:0] red;
    logic [FB+1:0] green;
    logic [FB+1:0] blue;
  } rgb_pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  hsv2rgb_hsv_if hsv_ch ();
  hsv2rgb_rgb_if rgb_ch ();

  hsv_to_rgb_converter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (hsv_ch.sink),
    .out_pix     (rgb_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Pixels waiting to be offered, and the colours still owed by the block.
  hsv_pixel_t pending_px[$];
  rgb_pixel_t expected_rgb[$];

  // Our own copy of hdr_mode, updated on the same edge as the register.
  logic hdr_copy;

  int unsigned src_gap;
  int unsigned src_calm;
  int unsigned snk_stall;
  int unsigned snk_calm;
  int unsigned mismatches;
  int unsigned cycles;
  rgb_pixel_t want_rgb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One level of the colour: V * (1 - S*x), where x is a fraction of one.
  // Every product truncates, and a factor that reaches zero or goes
  // negative (saturation above one) leaves the level at black.
  function automatic longint unsigned dim_level(longint unsigned v, longint unsigned s,
                                                longint unsigned x);
    longint unsigned sx;
    longint unsigned lvl;
    sx = (s * x) >> FB;
    if (sx >= UNITY) return 0;
    lvl = (v * (UNITY - sx)) >> FB;
    return (lvl > CHAN_MAX) ? CHAN_MAX : lvl;
  endfunction

  // Predicted colour for one pixel under the given hdr_mode.
  function automatic rgb_pixel_t predict_rgb(hsv_pixel_t px, logic hdr);
    longint unsigned v, s, h6, f, p, q, t;
    longint unsigned r, g, b;
    sector_t sec;
    v = px.val;
    s = px.sat;
    r = 0;
    g = 0;
    b = 0;
    if (s == 0) begin
      // A grey pixel passes the value straight through, even above 1.0 and
      // even with clamping on.
      r = v;
      g = v;
      b = v;
    end else if (v != 0) begin
      h6 = (longint'(px.hue) & FRAC_MASK) * 6;
      sec = sector_t'(h6[FB+2:FB]);
      f = h6 & FRAC_MASK;
      p = dim_level(v, s, UNITY);
      q = dim_level(v, s, f);
      t = dim_level(v, s, UNITY - f);
      case (sec)
        SEC_RED_TO_YELLOW: begin
          r = v; g = t; b = p;
        end
        SEC_YELLOW_TO_GREEN: begin
          r = q; g = v; b = p;
        end
        SEC_GREEN_TO_CYAN: begin
          r = p; g = v; b = t;
        end
        SEC_CYAN_TO_BLUE: begin
          r = p; g = q; b = v;
        end
        SEC_BLUE_TO_MAGENTA: begin
          r = t; g = p; b = v;
        end
        default: begin
          r = v; g = p; b = q;
        end
      endcase
      if (!hdr) begin
        if (r > UNITY) r = UNITY;
        if (g > UNITY) g = UNITY;
        if (b > UNITY) b = UNITY;
      end
    end
    predict_rgb.red   = r[FB+1:0];
    predict_rgb.green = g[FB+1:0];
    predict_rgb.blue  = b[FB+1:0];
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void check_channel(string chan, logic [FB+1:0] want,
                                        logic [FB+1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
    end
  endfunction

  task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v);
    hsv_pixel_t px;
    px.hue = h[FB-1:0];
    px.sat = s[FB:0];
    px.val = v[FB+1:0];
    pending_px.push_back(px);
  endtask

  // Wait until every queued pixel has been taken and every colour has come
  // back, then let the pipeline settle for a pause set by PIPE_DEPTH.
  // The queues and the handshake are looked at on the falling edge, once the
  // driver and the monitor have both finished with the rising one.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_px.size() != 0 || hsv_ch.valid || expected_rgb.size() != 0);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
  endtask

  // hdr_mode is only written here, with nothing in flight.
  task automatic write_hdr(logic mode);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic add_directed();
    int unsigned k;
    add_pixel(0, 0, 0);
    // Grey pixels, one of them well above 1.0, which is never clamped.
    add_pixel(12345, 0, 262143);
    add_pixel(0, 0, 65536);
    // Black: a saturated colour with zero value.
    add_pixel(40000, 65536, 0);
    add_pixel(0, 65536, 65536);
    add_pixel(65535, 65536, 65536);
    // Either side of the first sector boundary.
    add_pixel(10922, 65536, 65536);
    add_pixel(10923, 65536, 65536);
    // The middle of every sector, bright enough to clamp without hdr.
    for (k = 0; k < 6; k++) add_pixel(k * 10923 + 5461, 40000, 200000);
    // Saturation above 1.0 drives some levels to zero.
    add_pixel(30000, 131071, 100000);
    add_pixel(50000, 98304, 65536);
    add_pixel(65535, 131071, 262143);
    add_pixel(1, 1, 1);
    add_pixel(32768, 65535, 262143);
  endtask

  task automatic add_random(int unsigned count);
    int unsigned n, roll, s, v;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 10) s = 0;
      else if (roll < 20) s = 65536;
      else if (roll < 85) s = $urandom_range(65536);
      else s = $urandom_range(131071);
      roll = $urandom_range(99);
      if (roll < 8) v = 0;
      else if (roll < 60) v = $urandom_range(65536);
      else v = $urandom_range(262143);
      add_pixel($urandom_range(65535), s, v);
    end
  endtask

  // Stimulus: a directed set under both settings of hdr_mode, then random
  // phases that alternate it. Between phases the sender holds off until
  // every colour has come back.
  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    hsv_ch.valid      = 1'b0;
    hsv_ch.hue        = '0;
    hsv_ch.saturation = '0;
    hsv_ch.value      = '0;
    rgb_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The reset value of hdr_mode is used first, without a write.
    add_directed();
    wait_drained();
    write_hdr(1'b1);
    add_directed();
    wait_drained();
    write_hdr(1'b0);
    add_random(200);
    wait_drained();
    write_hdr(1'b1);
    add_random(200);
    wait_drained();
    write_hdr(1'b0);
    add_random(200);
    wait_drained();
    write_hdr(1'b1);
    add_random(200);
    wait_drained();

    if (mismatches == 0) begin
      $display("** hsv_to_rgb_converter_core: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter_core: FAILED **");
    end
    $finish;
  end

  // Pixel sender. A new pixel is offered only once the previous one has
  // been taken, and the idle count before the next is chosen as it goes out.
  // Now and then a calm stretch sends back to back.
  always @(posedge clk) begin
    if (!rst_n) begin
      hsv_ch.valid <= 1'b0;
      src_gap      <= 0;
      src_calm     <= 0;
    end else if (!hsv_ch.valid || hsv_ch.ready) begin
      if (src_gap != 0) begin
        hsv_ch.valid <= 1'b0;
        src_gap      <= src_gap - 1;
      end else if (pending_px.size() != 0) begin
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= pending_px[0].hue;
        hsv_ch.saturation <= pending_px[0].sat;
        hsv_ch.value      <= pending_px[0].val;
        void'(pending_px.pop_front());
        if (src_calm != 0) begin
          src_gap  <= 0;
          src_calm <= src_calm - 1;
        end else begin
          src_gap <= idle_len();
          if ($urandom_range(99) < 3) src_calm <= $urandom_range(80, 30);
        end
      end else begin
        hsv_ch.valid <= 1'b0;
      end
    end
  end

  // Colour receiver: stalls of random length, with calm stretches too.
  always @(posedge clk) begin
    if (!rst_n) begin
      rgb_ch.ready <= 1'b0;
      snk_stall    <= 0;
      snk_calm     <= 0;
    end else if (snk_stall != 0) begin
      rgb_ch.ready <= 1'b0;
      snk_stall    <= snk_stall - 1;
    end else begin
      rgb_ch.ready <= 1'b1;
      if (snk_calm != 0) begin
        snk_calm <= snk_calm - 1;
      end else if ($urandom_range(99) < 30) begin
        snk_stall <= idle_len();
        if ($urandom_range(99) < 3) snk_calm <= $urandom_range(80, 30);
      end
    end
  end

  // Monitor: every accepted pixel adds its colour to the expected queue;
  // every accepted colour is checked against the oldest entry.
  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_copy <= 1'b0;
    end else begin
      if (cfg_wr_en) hdr_copy <= cfg_wr_data;
      if (hsv_ch.valid && hsv_ch.ready) begin
        expected_rgb.push_back(predict_rgb({hsv_ch.hue, hsv_ch.saturation, hsv_ch.value},
                                           hdr_copy));
      end
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (expected_rgb.size() == 0) begin
          mismatches++;
          $display("%0t: colour with none expected, actual %0d %0d %0d", $time,
                   rgb_ch.red, rgb_ch.green, rgb_ch.blue);
        end else begin
          want_rgb = expected_rgb.pop_front();
          check_channel("red", want_rgb.red, rgb_ch.red);
          check_channel("green", want_rgb.green, rgb_ch.green);
          check_channel("blue", want_rgb.blue, rgb_ch.blue);
        end
      end
    end
  end

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** hsv_to_rgb_converter_core: FAILED **");
      $finish;
    end
  end

  initial cycles = 0;
  initial mismatches = 0;

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_hsv_if.sv
hw/rtl/hsv2rgb_rgb_if.sv
hw/rtl/hsv2rgb_sector.sv
hw/rtl/hsv2rgb_level.sv
hw/rtl/hsv2rgb_route.sv
hw/rtl/hsv_to_rgb_converter_core.sv
sim/testbench.sv
